[sv/vokt_pkg.sv]
// Shared types and codes for the value-ordered key table.
`timescale 1ns / 1ps

package vokt_pkg;

  localparam int KEY_FIELD_W   = 32;
  localparam int VALUE_FIELD_W = 32;
  localparam int TOTAL_FIELD_W = 5;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_ERASE  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_READY,
    ST_PLACE,
    ST_REPORT
  } seq_state_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic clr;
    logic remove;
    logic place;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]                       action;
    logic [KEY_FIELD_W-1:0]           key;
    logic signed [VALUE_FIELD_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic                             found;
    logic signed [VALUE_FIELD_W-1:0]  old_value;
    logic [KEY_FIELD_W-1:0]           least_key;
    logic signed [VALUE_FIELD_W-1:0]  least_value;
    logic [KEY_FIELD_W-1:0]           greatest_key;
    logic signed [VALUE_FIELD_W-1:0]  greatest_value;
    logic [TOTAL_FIELD_W-1:0]         entry_total;
    logic                             is_empty;
    logic                             dropped;
  } out_item_t;

endpackage

[sv/value_ordered_key_table.sv]
// Top level of the value-ordered key table: sequencer, cell chain and result register.
`timescale 1ns / 1ps
//
//  Channel  Ports                      Direction  Beat
//  -------  -------------------------  ---------  -------------------------------------
//  in       in_valid/in_stall/in_data  sink       action, key, value (one operation)
//  out      out_valid/out_stall/...    source     found, old value, extremes, count, flags
//
//  Sequence: for an insert or erase, the accepting edge removes any old pair
//  with the key from the cell chain (cells past it shift left); a clear
//  empties it. The next edge places an inserted pair (cells past the insert
//  point shift right). The result is registered once the result register is
//  free, on an edge that may accept the next item, so each item waits for the last result to load.
//  Reset: clears every cell valid bit, the count, the sequencer and the result
//  valid flag. Stalls: a result waiting on out_stall holds in_stall high in
//  the report state until it leaves.
//
//  The table is a row of ENTRIES cells kept sorted by (value, key), with valid
//  entries packed at the low end: cell 0 holds the least pair and the last
//  valid cell holds the greatest.

module value_ordered_key_table #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vokt_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vokt_pkg::out_item_t out_data
);
  import vokt_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  // Widen a stored key to the 32-bit field (zero-extend or truncate).
  function automatic logic [KEY_FIELD_W-1:0] key_to_field(input logic [KEY_BITS-1:0] k);
    logic [63:0] w;
    w = 64'(k);
    return w[KEY_FIELD_W-1:0];
  endfunction

  // Sign-extend or truncate a stored value to the 32-bit field.
  function automatic logic [VALUE_FIELD_W-1:0] value_to_field(
    input logic signed [VALUE_BITS-1:0] v
  );
    logic signed [63:0] w;
    w = 64'(v);
    return w[VALUE_FIELD_W-1:0];
  endfunction

  seq_state_t state_r, state_nxt;

  logic                         accept;
  logic                         load_out;
  cell_ctrl_t                   ctrl;

  // Incoming beat brought to storage widths.
  logic [63:0]                  key_wide, value_wide;
  logic [KEY_BITS-1:0]          in_key;
  logic signed [VALUE_BITS-1:0] in_value;

  // Item held across the place cycle.
  logic [KEY_BITS-1:0]          key_r;
  logic signed [VALUE_BITS-1:0] value_r;
  logic                         place_en_r;
  logic                         found_r;
  logic signed [VALUE_BITS-1:0] old_value_r;
  logic                         dropped_r;
  logic [CNT_W-1:0]             count_r, count_nxt;

  // Probe presented to the chain: incoming beat on accept, held item on place.
  logic [KEY_BITS-1:0]          probe_key;
  logic signed [VALUE_BITS-1:0] probe_value;

  logic                         cell_valid    [ENTRIES];
  logic [KEY_BITS-1:0]          cell_key      [ENTRIES];
  logic signed [VALUE_BITS-1:0] cell_value    [ENTRIES];
  logic                         cell_hit      [ENTRIES];
  logic                         cell_past_hit [ENTRIES];
  logic                         cell_place    [ENTRIES];

  logic                         any_hit;
  logic signed [VALUE_BITS-1:0] hit_value;
  logic [KEY_BITS-1:0]          top_key;
  logic signed [VALUE_BITS-1:0] top_value;
  logic                         is_insert, is_erase, is_clear;
  logic                         table_full;
  logic                         out_valid_r;
  out_item_t                    out_data_r;
  logic [63:0]                  cnt_wide;

  assign key_wide   = 64'(in_data.key);
  assign value_wide = 64'(unsigned'(in_data.value));
  assign in_key     = key_wide[KEY_BITS-1:0];
  assign in_value   = signed'(value_wide[VALUE_BITS-1:0]);

  assign is_insert  = (in_data.action == ACT_INSERT);
  assign is_erase   = (in_data.action == ACT_ERASE);
  assign is_clear   = (in_data.action == ACT_CLEAR);
  assign table_full = (count_r == FULL_CNT);

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_READY:  state_nxt = accept ? ST_PLACE : ST_READY;
      ST_PLACE:  state_nxt = ST_REPORT;
      ST_REPORT: begin
        if (load_out) begin
          state_nxt = accept ? ST_PLACE : ST_READY;
        end
      end
      default:   state_nxt = ST_READY;
    endcase
  end

  // Sequencer: outputs. A pending result must be captured before the chain
  // changes again, so the input stalls while the result register is blocked.
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state_r)
      ST_READY:  in_stall = 1'b0;
      ST_PLACE:  in_stall = 1'b1;
      ST_REPORT: begin
        load_out = !(out_valid_r && out_stall);
        in_stall = !load_out;
      end
      default:   in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    ctrl.clr    = accept && is_clear;
    ctrl.remove = accept && (is_insert || is_erase);
    ctrl.place  = (state_r == ST_PLACE) && place_en_r;
  end

  assign probe_key   = (state_r == ST_PLACE) ? key_r   : in_key;
  assign probe_value = (state_r == ST_PLACE) ? value_r : in_value;

  // Cell chain. Cell 0 sees an empty left neighbor, the last an empty right one.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                         l_valid, l_past_hit, l_place, r_valid;
    logic [KEY_BITS-1:0]          l_key, r_key;
    logic signed [VALUE_BITS-1:0] l_value, r_value;

    if (i == 0) begin : g_first
      assign l_valid    = 1'b0;
      assign l_key      = '0;
      assign l_value    = '0;
      assign l_past_hit = 1'b0;
      assign l_place    = 1'b0;
    end else begin : g_inner_l
      assign l_valid    = cell_valid[i-1];
      assign l_key      = cell_key[i-1];
      assign l_value    = cell_value[i-1];
      assign l_past_hit = cell_past_hit[i-1];
      assign l_place    = cell_place[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_key   = '0;
      assign r_value = '0;
    end else begin : g_inner_r
      assign r_valid = cell_valid[i+1];
      assign r_key   = cell_key[i+1];
      assign r_value = cell_value[i+1];
    end

    vokt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (ctrl),
      .new_key       (probe_key),
      .new_value     (probe_value),
      .left_valid    (l_valid),
      .left_key      (l_key),
      .left_value    (l_value),
      .left_past_hit (l_past_hit),
      .left_place    (l_place),
      .right_valid   (r_valid),
      .right_key     (r_key),
      .right_value   (r_value),
      .valid         (cell_valid[i]),
      .key           (cell_key[i]),
      .value         (cell_value[i]),
      .hit           (cell_hit[i]),
      .past_hit      (cell_past_hit[i]),
      .place         (cell_place[i])
    );
  end

  // Keys are unique, so at most one cell hits: an OR-mux picks its value.
  always_comb begin
    any_hit   = 1'b0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      any_hit   = any_hit | cell_hit[i];
      hit_value = hit_value | (cell_hit[i] ? cell_value[i] : '0);
    end
  end

  // Greatest pair sits in the last valid cell.
  always_comb begin
    top_key   = '0;
    top_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_valid[i] && ((i == ENTRIES - 1) || !cell_valid[(i + 1) % ENTRIES])) begin
        top_key   = top_key | cell_key[i];
        top_value = top_value | cell_value[i];
      end
    end
  end

  // Count: drop on a removal or clear, advance on a placement.
  always_comb begin
    count_nxt = count_r;
    if (accept && is_clear) begin
      count_nxt = '0;
    end else if (accept && (is_insert || is_erase) && any_hit) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (ctrl.place) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_READY;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the item on accept; the place cycle works from these.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r       <= in_key;
      value_r     <= in_value;
      found_r     <= any_hit;
      old_value_r <= any_hit ? hit_value : '0;
      place_en_r  <= is_insert && (any_hit || !table_full);
      dropped_r   <= is_insert && !any_hit && table_full;
    end
  end

  assign cnt_wide = 64'(count_r);

  // Result register: load from the settled chain after placement.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.found          <= found_r;
      out_data_r.old_value      <= value_to_field(old_value_r);
      out_data_r.least_key      <= cell_valid[0] ? key_to_field(cell_key[0]) : '0;
      out_data_r.least_value    <= cell_valid[0] ? value_to_field(cell_value[0]) : '0;
      out_data_r.greatest_key   <= key_to_field(top_key);
      out_data_r.greatest_value <= value_to_field(top_value);
      out_data_r.entry_total    <= cnt_wide[TOTAL_FIELD_W-1:0];
      out_data_r.is_empty       <= (count_r == '0);
      out_data_r.dropped        <= dropped_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/vokt_cell.sv]
// One slot of the sorted chain: holds a pair, shifts left on removal, right on placement.
`timescale 1ns / 1ps

module vokt_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vokt_pkg::cell_ctrl_t         ctrl,
  input  logic [KEY_BITS-1:0]          new_key,
  input  logic signed [VALUE_BITS-1:0] new_value,
  input  logic                         left_valid,
  input  logic [KEY_BITS-1:0]          left_key,
  input  logic signed [VALUE_BITS-1:0] left_value,
  input  logic                         left_past_hit,
  input  logic                         left_place,
  input  logic                         right_valid,
  input  logic [KEY_BITS-1:0]          right_key,
  input  logic signed [VALUE_BITS-1:0] right_value,
  output logic                         valid,
  output logic [KEY_BITS-1:0]          key,
  output logic signed [VALUE_BITS-1:0] value,
  output logic                         hit,
  output logic                         past_hit,
  output logic                         place
);
  import vokt_pkg::*;

  logic                         valid_r, valid_nxt;
  logic [KEY_BITS-1:0]          key_r, key_nxt;
  logic signed [VALUE_BITS-1:0] value_r, value_nxt;
  logic                         new_first;

  assign hit       = valid_r && (key_r == new_key);
  assign past_hit  = left_past_hit || hit;
  assign new_first = (new_value < value_r) || ((new_value == value_r) && (new_key < key_r));
  // Chain is packed and sorted, so this flag is a thermometer from the insert point on.
  assign place     = !valid_r || new_first;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.remove && past_hit) begin
      valid_nxt = right_valid;
      key_nxt   = right_key;
      value_nxt = right_value;
    end else if (ctrl.place && left_place) begin
      valid_nxt = left_valid;
      key_nxt   = left_key;
      value_nxt = left_value;
    end else if (ctrl.place && place) begin
      valid_nxt = 1'b1;
      key_nxt   = new_key;
      value_nxt = new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign value = value_r;

endmodule

[sv/vokt_checker.sv]
// Port-level checks for the value-ordered key table, bound to the top level.
`timescale 1ns / 1ps

module vokt_port_checks #(
  parameter int ENTRIES = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input vokt_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input vokt_pkg::out_item_t out_data
);
  import vokt_pkg::*;

  localparam logic [TOTAL_FIELD_W-1:0] FULL_TOTAL = TOTAL_FIELD_W'(ENTRIES);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The placement cycle always follows an accepted beat.
  a_place_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("beat accepted during placement cycle");

  // An empty table reports a zero count and zero extremes.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.entry_total == '0 && out_data.least_key == '0 &&
      out_data.least_value == '0 && out_data.greatest_key == '0 &&
      out_data.greatest_value == '0)
    else $error("empty table reported nonzero extremes");

  // A refused insert only happens for an absent key into a full table.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dropped |->
      !out_data.found && out_data.entry_total == FULL_TOTAL && !out_data.is_empty)
    else $error("insert refused without a full table");

endmodule

bind value_ordered_key_table vokt_port_checks #(.ENTRIES(ENTRIES)) u_vokt_checker (.*);

[bench/vokt_checker.sv]
// Checker for the value-ordered key table: predicts every result and compares it.
`timescale 1ns / 1ps

module vokt_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  vokt_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  vokt_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  open_count,
  output int                  checked_count,
  output int                  refused_count,
  output int                  full_count
);
  import vokt_pkg::*;

  localparam int SLOTS     = 16;
  localparam int PRINT_CAP = 40;

  // Shadow table: slot order does not matter, only the (value, key) order.
  bit                 row_live [SLOTS];
  logic [31:0]        row_key  [SLOTS];
  logic signed [31:0] row_val  [SLOTS];
  int                 live_total;

  out_item_t result_q [$];
  out_item_t want;
  out_item_t got;

  function automatic bit pair_first(logic signed [31:0] va, logic [31:0] ka,
                                    logic signed [31:0] vb, logic [31:0] kb);
    if (va != vb) return va < vb;
    return ka < kb;
  endfunction

  // Apply one operation to the shadow table and return the result it causes.
  function automatic out_item_t apply_op(in_item_t op);
    out_item_t r;
    int        i;
    int        hit;
    int        free_slot;
    int        lo;
    int        hi;
    r         = '0;
    hit       = -1;
    free_slot = -1;
    lo        = -1;
    hi        = -1;
    for (i = 0; i < SLOTS; i++) begin
      if (row_live[i] && row_key[i] == op.key && hit < 0) hit = i;
      if (!row_live[i] && free_slot < 0) free_slot = i;
    end
    r.found = (hit >= 0);
    if (hit >= 0) r.old_value = row_val[hit];
    case (action_t'(op.action))
      ACT_INSERT: begin
        if (hit >= 0) begin
          row_val[hit] = op.value;
        end else if (free_slot < 0) begin
          r.dropped = 1'b1;
        end else begin
          row_live[free_slot] = 1'b1;
          row_key[free_slot]  = op.key;
          row_val[free_slot]  = op.value;
          live_total++;
        end
      end
      ACT_ERASE: begin
        if (hit >= 0) begin
          row_live[hit] = 1'b0;
          live_total--;
        end
      end
      ACT_CLEAR: begin
        for (i = 0; i < SLOTS; i++) row_live[i] = 1'b0;
        live_total = 0;
      end
      default: ;
    endcase
    for (i = 0; i < SLOTS; i++) begin
      if (row_live[i]) begin
        if (lo < 0 || pair_first(row_val[i], row_key[i], row_val[lo], row_key[lo])) lo = i;
        if (hi < 0 || pair_first(row_val[hi], row_key[hi], row_val[i], row_key[i])) hi = i;
      end
    end
    if (lo >= 0) begin
      r.least_key   = row_key[lo];
      r.least_value = row_val[lo];
    end
    if (hi >= 0) begin
      r.greatest_key   = row_key[hi];
      r.greatest_value = row_val[hi];
    end
    r.entry_total = live_total[4:0];
    r.is_empty    = (live_total == 0);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] seen, logic [31:0] wanted);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("MISMATCH result %0d %s: got %h, want %h", checked_count, what, seen, wanted);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) row_live[i] = 1'b0;
      live_total = 0;
      result_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (result_q.size() == 0) begin
          report("result with nothing pending", '0, '0);
        end else begin
          want = result_q.pop_front();
          if (got.found !== want.found) report("found", got.found, want.found);
          if (got.old_value !== want.old_value)
            report("old_value", got.old_value, want.old_value);
          if (got.least_key !== want.least_key)
            report("least_key", got.least_key, want.least_key);
          if (got.least_value !== want.least_value)
            report("least_value", got.least_value, want.least_value);
          if (got.greatest_key !== want.greatest_key)
            report("greatest_key", got.greatest_key, want.greatest_key);
          if (got.greatest_value !== want.greatest_value)
            report("greatest_value", got.greatest_value, want.greatest_value);
          if (got.entry_total !== want.entry_total)
            report("entry_total", got.entry_total, want.entry_total);
          if (got.is_empty !== want.is_empty) report("is_empty", got.is_empty, want.is_empty);
          if (got.dropped !== want.dropped) report("dropped", got.dropped, want.dropped);
          checked_count++;
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_op(in_data);
        result_q.push_back(want);
        if (want.dropped) refused_count++;
        if (want.entry_total == SLOTS) full_count++;
      end
    end
    open_count = result_q.size();
  end

endmodule

[bench/tb.sv]
// Testbench top for the value-ordered key table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import vokt_pkg::*;

  localparam int RANDOM_OPS   = 1700;
  localparam int KEY_POOL     = 20;     // a few more keys than slots, so the table fills
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 800000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int open_count;
  int checked_count;
  int refused_count;
  int full_count;

  int          sent_count  = 0;
  int          calm_left   = 0;
  int          cycle_count = 0;
  int          stall_left  = 0;
  logic [31:0] key_pool [KEY_POOL];

  // Free-running clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  value_ordered_key_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  vokt_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .open_count    (open_count),
    .checked_count (checked_count),
    .refused_count (refused_count),
    .full_count    (full_count)
  );

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_count, open_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result-side back-pressure: hold out_stall for runs of random length.
  // Mostly short stalls, a few long ones, and now and then a long quiet
  // stretch so that results also drain at full rate.
  always @(posedge clk) begin
    int roll;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 7);
      end else if (roll < 85) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else if (roll < 95) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(8, 40);
      end else begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(50, 150);
      end
    end
  end

  // Value mix: full-range noise, a tight band around zero to force ties on
  // value (ordered then by key), the two extremes, and small signed numbers.
  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return $urandom;
    if (roll < 70) return $urandom_range(0, 4) - 2;
    if (roll < 80) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom_range(0, 255) - 128;
  endfunction

  // Offer one beat on the input channel and hold it until it is accepted.
  // Valid is lowered only when a gap follows, so a back-to-back beat never
  // sees valid dropped and raised in the same step.
  task automatic send_op(action_t act, logic [31:0] key, logic [31:0] value);
    in_item_t beat;
    int       gap;
    int       roll;
    beat.action = act;
    beat.key    = key;
    beat.value  = value;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55)      gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 95) gap = $urandom_range(4, 12);
      else if (roll < 98) gap = $urandom_range(20, 60);
      else begin
        calm_left = $urandom_range(20, 80);
        gap       = 0;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  initial begin
    logic [31:0] key;
    logic [31:0] value;
    action_t     act;
    int          roll;

    // Hold reset, then release it for good.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: operations on an empty table.
    send_op(ACT_LOOKUP, 32'h0000_0005, 32'h1234_5678);
    send_op(ACT_ERASE,  32'h0000_0005, 32'h0);
    send_op(ACT_CLEAR,  32'h0000_0000, 32'h0);

    // Directed: fill all sixteen slots. Keys span both extremes; values
    // include both extremes, ties at the minimum, the maximum and zero.
    for (int i = 0; i < 16; i++) begin
      key = (i == 1) ? 32'hFFFF_FFFF : i * 32'h0101_0101;
      case (i)
        0, 8:     value = 32'h8000_0000;
        1, 7:     value = 32'h7FFF_FFFF;
        2, 3, 4:  value = 32'h0;
        5:        value = 32'hFFFF_FFFF;
        6:        value = 32'h1;
        default:  value = $urandom;
      endcase
      send_op(ACT_INSERT, key, value);
    end

    // Directed: full table behavior, erase and lookup of present keys,
    // clear that still reports the key it names.
    send_op(ACT_INSERT, 32'hDEAD_BEEF, 32'h5555_AAAA);
    send_op(ACT_INSERT, 32'h0303_0303, 32'h7FFF_FFFF);
    send_op(ACT_ERASE,  32'hFFFF_FFFF, 32'h0);
    send_op(ACT_LOOKUP, 32'h0202_0202, 32'h0);
    send_op(ACT_CLEAR,  32'h0000_0000, 32'h0);

    // Random: keys mostly from a small pool so hits, updates, erases and
    // refused inserts all happen; the pool drifts and a few keys are fresh.
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2)       act = ACT_CLEAR;
      else if (roll < 47) act = ACT_INSERT;
      else if (roll < 70) act = ACT_ERASE;
      else                act = ACT_LOOKUP;
      if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(0, KEY_POOL - 1)] = $urandom;
      if ($urandom_range(0, 19) == 0) key = $urandom;
      else                            key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      send_op(act, key, pick_value());
    end
    in_valid <= 1'b0;

    // Drain: let the checker count the last beat, wait for every pending
    // result, then watch for strays.
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d operations and %0d checked results over %0d cycles.",
             sent_count, checked_count, cycle_count);
    $display("Table was full after %0d operations; %0d inserts were refused.",
             full_count, refused_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results pending", fail_count, open_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
